// ===== hdl/quadratic_real_root_solver_unit_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the quadratic real-root solver
// Wraps concurrent assertions clocked on aclk and held off during reset.
// ---------------------------------------------------------------------------
`ifndef QUADRATIC_REAL_ROOT_SOLVER_UNIT_DEFINES_SVH
`define QUADRATIC_REAL_ROOT_SOLVER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define QRR_CHECK(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("qrr check failed");
`define QRR_CHECK_OUT(lbl, cond, prop) \
    `QRR_CHECK(lbl, (m_tvalid && (cond)) |-> (prop))
`else
`define QRR_CHECK(lbl, prop)
`define QRR_CHECK_OUT(lbl, cond, prop)
`endif

`endif

// ===== hdl/qrr_pkg.sv =====
// ---------------------------------------------------------------------------
// qrr_pkg
// Shared widths, result kind codes and stage payload types.
// ---------------------------------------------------------------------------
`default_nettype none

package qrr_pkg;

    localparam int COEF_W     = 16;
    localparam int DISC_W     = 35;
    localparam int RAD_W      = 64;
    localparam int SQRT_W     = 32;
    localparam int SQ_REM_W   = 35;
    localparam int SQ_STAGES  = 32;
    localparam int NUM_W      = 34;
    localparam int MAG_W      = 33;
    localparam int DIV_STAGES = 33;
    localparam int RES_W      = 32;

    typedef logic [1:0] kind_t;

    localparam kind_t KIND_NOT_QUAD = 2'd0;
    localparam kind_t KIND_NO_REAL  = 2'd1;
    localparam kind_t KIND_ONE_ROOT = 2'd2;
    localparam kind_t KIND_TWO_ROOT = 2'd3;

    typedef struct packed {
        kind_t                    kind;
        logic signed [COEF_W-1:0] coef_a;
        logic signed [COEF_W-1:0] coef_b;
    } sq_side_t;

    typedef struct packed {
        logic [MAG_W-1:0]  num1_mag;
        logic [MAG_W-1:0]  num2_mag;
        logic              neg1;
        logic              neg2;
        logic [COEF_W-1:0] den;
        kind_t             kind;
    } div_in_t;

    typedef struct packed {
        logic [MAG_W-1:0] quo1;
        logic [MAG_W-1:0] quo2;
        logic             neg1;
        logic             neg2;
        kind_t            kind;
    } div_out_t;

endpackage

`default_nettype wire

// ===== hdl/qrr_sqrt.sv =====
// ---------------------------------------------------------------------------
// qrr_sqrt
// Pipelined integer square root, one result bit per register stage.
// ---------------------------------------------------------------------------
`default_nettype none

module qrr_sqrt
    import qrr_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [RAD_W-1:0]  in_rad,
    input  wire sq_side_t          in_side,
    output logic                   out_valid,
    output logic [SQRT_W-1:0]      out_root,
    output sq_side_t               out_side
);

    logic [SQ_STAGES-1:0] valid_reg;
    logic [SQ_STAGES-1:0] valid_next;
    logic [SQ_REM_W-1:0]  rem_reg   [SQ_STAGES];
    logic [SQ_REM_W-1:0]  rem_next  [SQ_STAGES];
    logic [SQRT_W-1:0]    root_reg  [SQ_STAGES];
    logic [SQRT_W-1:0]    root_next [SQ_STAGES];
    logic [RAD_W-1:0]     x_reg     [SQ_STAGES];
    logic [RAD_W-1:0]     x_next    [SQ_STAGES];
    sq_side_t             side_reg  [SQ_STAGES];
    sq_side_t             side_next [SQ_STAGES];

    always_comb begin
        logic [SQ_REM_W-1:0] src_rem;
        logic [SQRT_W-1:0]   src_root;
        logic [RAD_W-1:0]    src_x;
        logic [SQ_REM_W-1:0] shifted;
        logic [SQ_REM_W-1:0] trial;
        for (int k = 0; k < SQ_STAGES; k++) begin
            if (k == 0) begin
                src_rem       = '0;
                src_root      = '0;
                src_x         = in_rad;
                valid_next[k] = in_valid;
                side_next[k]  = in_side;
            end else begin
                src_rem       = rem_reg[k-1];
                src_root      = root_reg[k-1];
                src_x         = x_reg[k-1];
                valid_next[k] = valid_reg[k-1];
                side_next[k]  = side_reg[k-1];
            end
            shifted   = {src_rem[SQ_REM_W-3:0], src_x[RAD_W-1:RAD_W-2]};
            trial     = {1'b0, src_root, 2'b01};
            x_next[k] = {src_x[RAD_W-3:0], 2'b00};
            if (shifted >= trial) begin
                rem_next[k]  = shifted - trial;
                root_next[k] = {src_root[SQRT_W-2:0], 1'b1};
            end else begin
                rem_next[k]  = shifted;
                root_next[k] = {src_root[SQRT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < SQ_STAGES; k++) begin
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
                x_reg[k]    <= x_next[k];
                side_reg[k] <= side_next[k];
            end
        end
    end

    assign out_valid = valid_reg[SQ_STAGES-1];
    assign out_root  = root_reg[SQ_STAGES-1];
    assign out_side  = side_reg[SQ_STAGES-1];

endmodule

`default_nettype wire

// ===== hdl/qrr_div.sv =====
// ---------------------------------------------------------------------------
// qrr_div
// Two-lane pipelined restoring divider sharing one divisor, one quotient
// bit per register stage.
// ---------------------------------------------------------------------------
`default_nettype none

module qrr_div
    import qrr_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    en,
    input  wire logic    in_valid,
    input  wire div_in_t in_data,
    output logic         out_valid,
    output div_out_t     out_data
);

    logic [DIV_STAGES-1:0] valid_reg;
    logic [DIV_STAGES-1:0] valid_next;
    div_in_t               num_reg   [DIV_STAGES];
    div_in_t               num_next  [DIV_STAGES];
    logic [COEF_W-1:0]     rem1_reg  [DIV_STAGES];
    logic [COEF_W-1:0]     rem1_next [DIV_STAGES];
    logic [COEF_W-1:0]     rem2_reg  [DIV_STAGES];
    logic [COEF_W-1:0]     rem2_next [DIV_STAGES];
    logic [MAG_W-1:0]      q1_reg    [DIV_STAGES];
    logic [MAG_W-1:0]      q1_next   [DIV_STAGES];
    logic [MAG_W-1:0]      q2_reg    [DIV_STAGES];
    logic [MAG_W-1:0]      q2_next   [DIV_STAGES];

    always_comb begin
        div_in_t           src;
        logic [COEF_W-1:0] src_r1;
        logic [COEF_W-1:0] src_r2;
        logic [MAG_W-1:0]  src_q1;
        logic [MAG_W-1:0]  src_q2;
        logic [COEF_W:0]   t1;
        logic [COEF_W:0]   t2;
        for (int k = 0; k < DIV_STAGES; k++) begin
            if (k == 0) begin
                src           = in_data;
                src_r1        = '0;
                src_r2        = '0;
                src_q1        = '0;
                src_q2        = '0;
                valid_next[k] = in_valid;
            end else begin
                src           = num_reg[k-1];
                src_r1        = rem1_reg[k-1];
                src_r2        = rem2_reg[k-1];
                src_q1        = q1_reg[k-1];
                src_q2        = q2_reg[k-1];
                valid_next[k] = valid_reg[k-1];
            end
            t1 = {src_r1, src.num1_mag[MAG_W-1]};
            t2 = {src_r2, src.num2_mag[MAG_W-1]};
            num_next[k]          = src;
            num_next[k].num1_mag = {src.num1_mag[MAG_W-2:0], 1'b0};
            num_next[k].num2_mag = {src.num2_mag[MAG_W-2:0], 1'b0};
            if (t1 >= {1'b0, src.den}) begin
                rem1_next[k] = COEF_W'(t1 - {1'b0, src.den});
                q1_next[k]   = {src_q1[MAG_W-2:0], 1'b1};
            end else begin
                rem1_next[k] = t1[COEF_W-1:0];
                q1_next[k]   = {src_q1[MAG_W-2:0], 1'b0};
            end
            if (t2 >= {1'b0, src.den}) begin
                rem2_next[k] = COEF_W'(t2 - {1'b0, src.den});
                q2_next[k]   = {src_q2[MAG_W-2:0], 1'b1};
            end else begin
                rem2_next[k] = t2[COEF_W-1:0];
                q2_next[k]   = {src_q2[MAG_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < DIV_STAGES; k++) begin
                num_reg[k]  <= num_next[k];
                rem1_reg[k] <= rem1_next[k];
                rem2_reg[k] <= rem2_next[k];
                q1_reg[k]   <= q1_next[k];
                q2_reg[k]   <= q2_next[k];
            end
        end
    end

    assign out_valid     = valid_reg[DIV_STAGES-1];
    assign out_data.quo1 = q1_reg[DIV_STAGES-1];
    assign out_data.quo2 = q2_reg[DIV_STAGES-1];
    assign out_data.neg1 = num_reg[DIV_STAGES-1].neg1;
    assign out_data.neg2 = num_reg[DIV_STAGES-1].neg2;
    assign out_data.kind = num_reg[DIV_STAGES-1].kind;

endmodule

`default_nettype wire

// ===== hdl/quadratic_real_root_solver_unit.sv =====
// ---------------------------------------------------------------------------
// quadratic_real_root_solver_unit
// Classifies a*x^2 + b*x + c and returns its real roots in Q16.16.
// ---------------------------------------------------------------------------
// Usage:
//   Slave stream carries one coefficient set per transaction (Q8.8 each).
//   Master stream returns one result transaction per input transaction,
//   in order: both roots in tdata, kind and overflow flag in tuser.
//   From input acceptance to m_tvalid a transaction passes two stages
//   for products and discriminant, 32 square-root stages (one root bit
//   each), one numerator stage, 33 divider stages (one quotient bit
//   each) and the output register. Every stage can hold one transaction.
//   Throughput is one transaction per cycle unless the receiver stalls.
//   Reset clears all stage valid bits; nothing is pending after reset.
//   When the receiver stalls, the whole pipeline holds and s_tready drops,
//   so no transaction is lost or repeated.
// ---------------------------------------------------------------------------
`default_nettype none

module quadratic_real_root_solver_unit
    import qrr_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // coef_a, coef_b, coef_c
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // root_one, root_two
    output logic [2:0]       m_tuser    // root_kind, overflow
);

`include "quadratic_real_root_solver_unit_defines.svh"

    localparam logic signed [DISC_W-1:0] RES_MAX = DISC_W'(64'sd2147483647);
    localparam logic signed [DISC_W-1:0] RES_MIN = -DISC_W'(64'sd2147483648);

    logic en;

    logic                       p1_valid_reg;
    logic signed [COEF_W-1:0]   p1_a_reg;
    logic signed [COEF_W-1:0]   p1_b_reg;
    logic signed [2*COEF_W-1:0] p1_bb_reg;
    logic signed [2*COEF_W-1:0] p1_ac_reg;

    logic                     p2_valid_reg;
    logic signed [COEF_W-1:0] p2_a_reg;
    logic signed [COEF_W-1:0] p2_b_reg;
    logic signed [DISC_W-1:0] p2_d_reg;
    logic signed [DISC_W-1:0] disc_next;

    kind_t            sq_kind;
    logic [RAD_W-1:0] sq_rad;
    sq_side_t         sq_side_in;
    logic             sq_valid;
    logic [SQRT_W-1:0] sq_root;
    sq_side_t         sq_side_out;

    logic signed [NUM_W-1:0] nb;
    logic signed [NUM_W-1:0] n1;
    logic signed [NUM_W-1:0] n2;
    logic [NUM_W-1:0]        n1_abs;
    logic [NUM_W-1:0]        n2_abs;
    logic [COEF_W:0]         a_abs;
    div_in_t                 div_next;
    div_in_t                 div_reg;
    logic                    p4_valid_reg;

    logic     dv_valid;
    div_out_t dv_data;

    logic signed [DISC_W-1:0] v1;
    logic signed [DISC_W-1:0] v2;
    logic [RES_W-1:0]         r1_next;
    logic [RES_W-1:0]         r2_next;
    logic                     ovf_next;

    logic             out_valid_reg;
    logic [RES_W-1:0] out_r1_reg;
    logic [RES_W-1:0] out_r2_reg;
    kind_t            out_kind_reg;
    logic             out_ovf_reg;

    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            p4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            p1_valid_reg  <= s_tvalid;
            p2_valid_reg  <= p1_valid_reg;
            p4_valid_reg  <= sq_valid;
            out_valid_reg <= dv_valid;
        end
    end

    assign disc_next = DISC_W'(p1_bb_reg) - (DISC_W'(p1_ac_reg) <<< 2);

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_a_reg  <= s_tdata[15:0];
            p1_b_reg  <= s_tdata[31:16];
            p1_bb_reg <= $signed(s_tdata[31:16]) * $signed(s_tdata[31:16]);
            p1_ac_reg <= $signed(s_tdata[15:0]) * $signed(s_tdata[47:32]);
            p2_a_reg  <= p1_a_reg;
            p2_b_reg  <= p1_b_reg;
            p2_d_reg  <= disc_next;
        end
    end

    always_comb begin
        priority if (p2_a_reg == '0) begin
            sq_kind = KIND_NOT_QUAD;
        end else if (p2_d_reg[DISC_W-1]) begin
            sq_kind = KIND_NO_REAL;
        end else if (p2_d_reg == '0) begin
            sq_kind = KIND_ONE_ROOT;
        end else begin
            sq_kind = KIND_TWO_ROOT;
        end
        sq_rad = (sq_kind == KIND_TWO_ROOT) ? {p2_d_reg[33:0], 30'b0} : '0;
        sq_side_in.kind   = sq_kind;
        sq_side_in.coef_a = p2_a_reg;
        sq_side_in.coef_b = p2_b_reg;
    end

    qrr_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (p2_valid_reg),
        .in_rad    (sq_rad),
        .in_side   (sq_side_in),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_side_out)
    );

    // numerators: -B * 2^15 +/- S, divided by A
    always_comb begin
        nb     = -(NUM_W'(sq_side_out.coef_b) <<< 15);
        n1     = nb + $signed({2'b00, sq_root});
        n2     = nb - $signed({2'b00, sq_root});
        n1_abs = n1[NUM_W-1] ? NUM_W'(-n1) : NUM_W'(n1);
        n2_abs = n2[NUM_W-1] ? NUM_W'(-n2) : NUM_W'(n2);
        a_abs  = sq_side_out.coef_a[COEF_W-1]
                 ? (COEF_W+1)'(-$signed({sq_side_out.coef_a[COEF_W-1], sq_side_out.coef_a}))
                 : {1'b0, sq_side_out.coef_a};
        div_next.num1_mag = n1_abs[MAG_W-1:0];
        div_next.num2_mag = n2_abs[MAG_W-1:0];
        div_next.neg1     = n1[NUM_W-1] ^ sq_side_out.coef_a[COEF_W-1];
        div_next.neg2     = n2[NUM_W-1] ^ sq_side_out.coef_a[COEF_W-1];
        div_next.den      = a_abs[COEF_W-1:0];
        div_next.kind     = sq_side_out.kind;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            div_reg <= div_next;
        end
    end

    qrr_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (p4_valid_reg),
        .in_data   (div_reg),
        .out_valid (dv_valid),
        .out_data  (dv_data)
    );

    always_comb begin
        v1 = dv_data.neg1 ? -$signed({2'b00, dv_data.quo1}) : $signed({2'b00, dv_data.quo1});
        v2 = dv_data.neg2 ? -$signed({2'b00, dv_data.quo2}) : $signed({2'b00, dv_data.quo2});
        ovf_next = 1'b0;
        priority if (v1 > RES_MAX) begin
            r1_next  = RES_MAX[RES_W-1:0];
            ovf_next = 1'b1;
        end else if (v1 < RES_MIN) begin
            r1_next  = RES_MIN[RES_W-1:0];
            ovf_next = 1'b1;
        end else begin
            r1_next = v1[RES_W-1:0];
        end
        priority if (v2 > RES_MAX) begin
            r2_next  = RES_MAX[RES_W-1:0];
            ovf_next = 1'b1;
        end else if (v2 < RES_MIN) begin
            r2_next  = RES_MIN[RES_W-1:0];
            ovf_next = 1'b1;
        end else begin
            r2_next = v2[RES_W-1:0];
        end
        if (dv_data.kind == KIND_NOT_QUAD || dv_data.kind == KIND_NO_REAL) begin
            r1_next  = '0;
            r2_next  = '0;
            ovf_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_r1_reg   <= r1_next;
            out_r2_reg   <= r2_next;
            out_kind_reg <= dv_data.kind;
            out_ovf_reg  <= ovf_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_r2_reg, out_r1_reg};
    assign m_tuser  = {out_ovf_reg, out_kind_reg};

    `QRR_CHECK_OUT(a_ovf_two_only, m_tuser[1:0] != KIND_TWO_ROOT, !m_tuser[2])
    `QRR_CHECK_OUT(a_zero_no_root, m_tuser[1:0] == KIND_NOT_QUAD || m_tuser[1:0] == KIND_NO_REAL, m_tdata == '0)
    `QRR_CHECK_OUT(a_one_root_eq, m_tuser[1:0] == KIND_ONE_ROOT, m_tdata[31:0] == m_tdata[63:32])
    `QRR_CHECK(a_stall_ready, (m_tvalid && !m_tready) |-> !s_tready)

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// ---------------------------------------------------------------------------
// tb
// Stream testbench for the quadratic real-root solver: directed and random
// coefficient sets, random source gaps and sink stalls, in-order compare of
// kind, both roots and overflow against an integer root predictor.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
    import qrr_pkg::*;

    typedef struct packed {
        logic signed [15:0] a;
        logic signed [15:0] b;
        logic signed [15:0] c;
    } coef_set_t;

    typedef struct packed {
        kind_t              kind;
        logic signed [31:0] r1;
        logic signed [31:0] r2;
        logic               ovf;
    } roots_t;

    localparam int N_RANDOM   = 1900;
    localparam int WDOG_LIMIT = 5000;
    localparam int DRAIN      = 100;
    localparam int HOLD_AT    = 500;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic [2:0]  m_tuser;

    coef_set_t coef_queue[$];
    roots_t    expected_roots[$];
    int        src_gap;
    int        sink_gap;
    int        long_hold;
    int        sink_txns;
    int        mismatches = 0;
    int        idle_cycles;

    quadratic_real_root_solver_unit dut (.*);

    always begin
        aclk = 1'b1; #5;
        aclk = 1'b0; #5;
    end

    function automatic logic [63:0] int_sqrt(logic [63:0] x);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x   = x - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic signed [31:0] sat32(longint v, ref logic ovf);
        if (v > 64'sd2147483647) begin
            ovf = 1'b1;
            return 32'sh7FFFFFFF;
        end
        if (v < -64'sd2147483648) begin
            ovf = 1'b1;
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic roots_t solve_roots(coef_set_t cs);
        roots_t r;
        longint a, b, c, d, s, nb, den;
        logic   ovf;
        a = cs.a;
        b = cs.b;
        c = cs.c;
        r = '0;
        ovf = 1'b0;
        if (a == 0) begin
            r.kind = KIND_NOT_QUAD;
        end else begin
            d = b * b - 4 * a * c;
            if (d < 0) begin
                r.kind = KIND_NO_REAL;
            end else if (d == 0) begin
                r.kind = KIND_ONE_ROOT;
                r.r1 = 32'(((-b) * 65536) / (2 * a));
                r.r2 = r.r1;
            end else begin
                s   = int_sqrt(d << 30);
                nb  = -b * (64'sd1 << 15);
                den = 2 * a * (64'sd1 << 15);
                r.kind = KIND_TWO_ROOT;
                r.r1 = sat32(((nb + s) * 65536) / den, ovf);
                r.r2 = sat32(((nb - s) * 65536) / den, ovf);
            end
        end
        r.ovf = ovf;
        return r;
    endfunction

    function automatic logic [15:0] rand_coef();
        unique case ($urandom_range(0, 5))
            0: return 16'(16'h8000 + $urandom_range(0, 3));
            1: return 16'(16'h7FFF - $urandom_range(0, 3));
            2: return 16'($signed($urandom_range(0, 16)) - 8);
            3: return 16'($signed($urandom_range(0, 1024)) - 512);
            default: return 16'($urandom());
        endcase
    endfunction

    always @(posedge aclk) begin
        coef_set_t next_cs;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            src_gap  <= 0;
        end else if (!s_tvalid || s_tready) begin
            if (src_gap > 0) begin
                s_tvalid <= 1'b0;
                src_gap  <= src_gap - 1;
            end else if (coef_queue.size() > 0) begin
                next_cs = coef_queue.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {next_cs.c, next_cs.b, next_cs.a};
                src_gap  <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8) : 0;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            expected_roots.push_back(
                solve_roots({s_tdata[15:0], s_tdata[31:16], s_tdata[47:32]}));
    end

    always @(posedge aclk) begin
        int gap_draw;
        if (!aresetn) begin
            m_tready  <= 1'b0;
            sink_gap  <= 0;
            long_hold <= 0;
            sink_txns <= 0;
        end else if (long_hold > 0) begin
            m_tready  <= 1'b0;
            long_hold <= long_hold - 1;
        end else if (m_tvalid && m_tready) begin
            sink_txns <= sink_txns + 1;
            gap_draw = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 8) : 0;
            if (sink_txns == HOLD_AT || $urandom_range(0, 199) == 0) begin
                m_tready  <= 1'b0;
                long_hold <= $urandom_range(100, 300);
            end else if (gap_draw == 0) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b0;
                sink_gap <= gap_draw - 1;
            end
        end else if (sink_gap > 0) begin
            m_tready <= 1'b0;
            sink_gap <= sink_gap - 1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        roots_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.kind = m_tuser[1:0];
            got.ovf  = m_tuser[2];
            got.r1   = m_tdata[31:0];
            got.r2   = m_tdata[63:32];
            if (expected_roots.size() == 0) begin
                mismatches = mismatches + 1;
                if (mismatches <= 10)
                    $display("unexpected result transaction: %p", got);
            end else begin
                want = expected_roots.pop_front();
                if (got !== want) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("root mismatch: expected %p, actual %p", want, got);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        coef_set_t cs;
        aresetn = 1'b0;
        // directed: not quadratic, no roots, double root, two roots, extremes
        coef_queue.push_back({16'sd0, 16'sd256, 16'sd256});
        coef_queue.push_back({16'sd0, 16'sh8000, 16'sh7FFF});
        coef_queue.push_back({16'sd256, 16'sd0, 16'sd256});
        coef_queue.push_back({16'sd256, -16'sd512, 16'sd256});
        coef_queue.push_back({16'sd256, 16'sd0, 16'sd0});
        coef_queue.push_back({-16'sd256, 16'sd512, -16'sd256});
        coef_queue.push_back({16'sd256, 16'sd0, -16'sd256});
        coef_queue.push_back({16'sd256, -16'sd768, 16'sd512});
        coef_queue.push_back({16'sd1, 16'sh7FFF, 16'sd0});
        coef_queue.push_back({16'sd1, 16'sh8000, 16'sd0});
        coef_queue.push_back({-16'sd1, 16'sh8000, 16'sh7FFF});
        coef_queue.push_back({16'sh8000, 16'sh8000, 16'sh8000});
        coef_queue.push_back({16'sh7FFF, 16'sh7FFF, 16'sh7FFF});
        coef_queue.push_back({16'sh8000, 16'sh7FFF, 16'sh7FFF});
        coef_queue.push_back({16'sh7FFF, 16'sh8000, 16'sh8000});
        coef_queue.push_back({16'sd1, 16'sd2, 16'sd1});
        coef_queue.push_back({16'sd1, 16'sd0, 16'sh8000});
        coef_queue.push_back({16'hFFFF, 16'hFFFF, 16'hFFFF});
        coef_queue.push_back({16'sd4, 16'sd4, 16'sd1});
        for (int i = 0; i < N_RANDOM; i++) begin
            cs.a = rand_coef();
            cs.b = rand_coef();
            cs.c = rand_coef();
            // some perfect squares give double roots: b = 2k, a*c = k*k
            if ($urandom_range(0, 9) == 0) begin
                cs.a = 16'($signed($urandom_range(1, 200)) * ($urandom_range(0, 1) ? 1 : -1));
                cs.c = cs.a;
                cs.b = 16'(2 * cs.a * ($urandom_range(0, 1) ? 1 : -1));
            end
            coef_queue.push_back(cs);
        end
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        wait (coef_queue.size() == 0 && !s_tvalid);
        wait (expected_roots.size() == 0);
        repeat (DRAIN) @(posedge aclk);
        if (mismatches == 0 && expected_roots.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
